[rtl/core/bmg_pkg.sv]
// Shared widths, constants and types for the Box-Muller Gaussian pair generator.
`default_nettype none
package bmg_pkg;

    localparam int E_W        = 6;   // top-bit index of the radius code plus one
    localparam int X_W        = 31;  // normalised log2 operand, Q30 in [1,2)
    localparam int FRAC_W     = 30;  // log2 fraction bits
    localparam int L24_W      = 30;  // -log2(u1) in Q24
    localparam int T_W        = 31;  // -2 ln(u1) in Q24
    localparam int V_W        = 55;  // square root operand and partial root
    localparam int R_W        = 28;  // radius, Q24
    localparam int TH_W       = 31;  // angle within quadrant, Q30 radians
    localparam int X2_W       = 32;  // angle squared, Q30
    localparam int TERM_W     = 32;  // series term
    localparam int SUM_W      = 35;  // signed series sum
    localparam int MAG_W      = 32;  // trig magnitude
    localparam int PROD_W     = R_W + MAG_W;
    localparam int SAMPLE_W   = 16;

    localparam int LOG_STEPS  = 30;
    localparam int SQRT_STEPS = 28;
    localparam int TRIG_STEPS = 8;
    localparam int SIN_STEPS  = 7;

    localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    typedef enum logic [1:0] {
        QUAD_I   = 2'd0,
        QUAD_II  = 2'd1,
        QUAD_III = 2'd2,
        QUAD_IV  = 2'd3
    } t_quad;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sin_smp;
        logic [SAMPLE_W-1:0] cos_smp;
    } t_pair;

endpackage
`default_nettype wire

[rtl/core/box_muller_gaussian_pair.sv]
// Box-Muller Gaussian pair generator, top level.
// Slave stream takes one word per pair: two uniform codes, radius code and
// angle code. Master stream returns two samples per word accepted:
// r*cos(2*pi*u2) first, then r*sin(2*pi*u2) with tlast high. Samples are
// signed, SAMPLE_FRAC_BITS fraction bits, rounded and saturated to 16 bits.
// The datapath is one row of registered cells: an input stage, a normalise
// stage, 30 log2 squaring cells, two radius stages, 28 square-root cells, two
// angle stages, eight two-stage Taylor cells and two output scaling stages.
// The sine word follows the cosine word in the cycle after the receiver
// takes the cosine word.
// The single output stream carries two samples per input word, so it bounds
// the sustained rate of input words; the input may still be taken every
// cycle until the row of cells fills.
// When the receiver stalls, a pending pair register absorbs one pair; once
// both it and the last cell are full the whole row holds and tready drops.
// Reset (synchronous, active low) clears all valid flags and tlast; nothing else.
`default_nettype none
module box_muller_gaussian_pair #(
    parameter int UNIFORM_BITS     = 16,
    parameter int SAMPLE_FRAC_BITS = 12
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // [15:0] uniform_radius, [31:16] uniform_angle
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,   // [15:0] sample
    output logic             o_m_axis_tlast
);

    localparam int UB   = UNIFORM_BITS;
    localparam int SH   = 54 - SAMPLE_FRAC_BITS;
    localparam int LPW  = bmg_pkg::E_W + UB;
    localparam int TPW  = bmg_pkg::R_W + 2;

    logic en;
    logic full;
    logic last_vld;

    // stage 0: input word
    logic [31:0]   radius_ext, angle_ext;
    logic          r_s0_vld;
    logic [UB:0]   r_s0_m;
    logic [UB-1:0] r_s0_c2;

    // stage 1: normalise
    logic [bmg_pkg::E_W-1:0] e;
    logic [63:0]             m64, x64;
    logic                    r_s1_vld;
    logic [bmg_pkg::X_W-1:0] r_s1_x;
    logic [bmg_pkg::E_W-1:0] r_s1_e;
    logic [UB-1:0]           r_s1_c2;

    logic                        lg_v [0:bmg_pkg::LOG_STEPS];
    logic [bmg_pkg::X_W-1:0]     lg_x [0:bmg_pkg::LOG_STEPS];
    logic [bmg_pkg::FRAC_W-1:0]  lg_f [0:bmg_pkg::LOG_STEPS];
    logic [LPW-1:0]              lg_p [0:bmg_pkg::LOG_STEPS];

    // radius stages
    logic [bmg_pkg::E_W-1:0]   lg_e;
    logic [UB-1:0]             lg_c2;
    logic [bmg_pkg::E_W-1:0]   diff;
    logic [35:0]               l_full;
    logic                      r_l_vld;
    logic [bmg_pkg::L24_W-1:0] r_l24;
    logic [UB-1:0]             r_l_c2;
    logic [60:0]               t_prod;
    logic                      r_t_vld;
    logic [bmg_pkg::T_W-1:0]   r_t;
    logic [UB-1:0]             r_t_c2;

    logic                    sq_v [0:bmg_pkg::SQRT_STEPS];
    logic [bmg_pkg::V_W-1:0] sq_x [0:bmg_pkg::SQRT_STEPS];
    logic [bmg_pkg::V_W-1:0] sq_r [0:bmg_pkg::SQRT_STEPS];
    logic [UB-1:0]           sq_p [0:bmg_pkg::SQRT_STEPS];

    // angle stages
    logic [31:0]              turn;
    logic [60:0]              th_prod;
    logic                     r_a_vld;
    logic [bmg_pkg::R_W-1:0]  r_a_r;
    logic [bmg_pkg::TH_W-1:0] r_a_th;
    logic [1:0]               r_a_quad;
    logic [61:0]              x2_prod;
    logic                     r_x_vld;
    logic [bmg_pkg::R_W-1:0]  r_x_r;
    logic [bmg_pkg::TH_W-1:0] r_x_th;
    logic [bmg_pkg::X2_W-1:0] r_x_x2;
    logic [1:0]               r_x_quad;

    logic                              tr_v  [0:bmg_pkg::TRIG_STEPS];
    logic [bmg_pkg::X2_W-1:0]          tr_x2 [0:bmg_pkg::TRIG_STEPS];
    logic [bmg_pkg::TERM_W-1:0]        tr_st [0:bmg_pkg::TRIG_STEPS];
    logic [bmg_pkg::TERM_W-1:0]        tr_ct [0:bmg_pkg::TRIG_STEPS];
    logic signed [bmg_pkg::SUM_W-1:0]  tr_ss [0:bmg_pkg::TRIG_STEPS];
    logic signed [bmg_pkg::SUM_W-1:0]  tr_cs [0:bmg_pkg::TRIG_STEPS];
    logic [TPW-1:0]                    tr_p  [0:bmg_pkg::TRIG_STEPS];

    // output scaling
    logic signed [bmg_pkg::SUM_W-1:0] s_fin, c_fin, cv, sv, c_abs, s_abs;
    logic                      r_q_vld;
    logic [bmg_pkg::R_W-1:0]   r_q_r;
    logic                      r_q_cneg, r_q_sneg;
    logic [bmg_pkg::MAG_W-1:0] r_q_cmag, r_q_smag;
    logic                      r_p_vld;
    logic                      r_p_cneg, r_p_sneg;
    logic [bmg_pkg::PROD_W-1:0] r_p_c, r_p_s;
    bmg_pkg::t_pair            pair;

    function automatic logic [15:0] f_scale(input logic [bmg_pkg::PROD_W-1:0] p,
                                            input logic neg);
        logic [63:0] rp;
        logic [15:0] res;
        rp = (64'(p) + (64'd1 << (SH - 1))) >> SH;
        if (neg) begin
            res = (rp > 64'd32768) ? 16'h8000 : 16'(64'd0 - rp);
        end else begin
            res = (rp > 64'd32767) ? 16'h7FFF : rp[15:0];
        end
        return res;
    endfunction

    // whole row advances together; held only when a finished pair has nowhere to go
    assign en              = !(last_vld && full);
    assign o_s_axis_tready = en;

    assign radius_ext = 32'(i_s_axis_tdata[15:0]);
    assign angle_ext  = 32'(i_s_axis_tdata[31:16]);

    always_comb begin
        e = '0;
        for (int i = 0; i <= UB; i++) begin
            if (r_s0_m[i]) begin
                e = bmg_pkg::E_W'(i);
            end
        end
        m64 = 64'(r_s0_m);
        if (e <= 6'd30) begin
            x64 = m64 << (6'd30 - e);
        end else begin
            x64 = m64 >> (e - 6'd30);
        end
    end

    always_comb begin
        lg_e    = lg_p[bmg_pkg::LOG_STEPS][LPW-1:UB];
        lg_c2   = lg_p[bmg_pkg::LOG_STEPS][UB-1:0];
        diff    = bmg_pkg::E_W'(UB) - lg_e;
        l_full  = {diff, 30'd0} - 36'(lg_f[bmg_pkg::LOG_STEPS]);
        t_prod  = 61'(r_l24) * 61'(bmg_pkg::TWO_LN2_Q30);
        turn    = 32'(64'(sq_p[bmg_pkg::SQRT_STEPS]) << (32 - UB));
        th_prod = 61'(turn[29:0]) * 61'(bmg_pkg::HALF_PI_Q30);
        x2_prod = 62'(r_a_th) * 62'(r_a_th);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_l_vld  <= 1'b0;
            r_t_vld  <= 1'b0;
            r_a_vld  <= 1'b0;
            r_x_vld  <= 1'b0;
            r_q_vld  <= 1'b0;
            r_p_vld  <= 1'b0;
        end else if (en) begin
            r_s0_vld <= i_s_axis_tvalid;
            r_s1_vld <= r_s0_vld;
            r_l_vld  <= lg_v[bmg_pkg::LOG_STEPS];
            r_t_vld  <= r_l_vld;
            r_a_vld  <= sq_v[bmg_pkg::SQRT_STEPS];
            r_x_vld  <= r_a_vld;
            r_q_vld  <= tr_v[bmg_pkg::TRIG_STEPS];
            r_p_vld  <= r_q_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_m   <= {1'b0, radius_ext[UB-1:0]} + (UB+1)'(1);
            r_s0_c2  <= angle_ext[UB-1:0];
            r_s1_x   <= x64[bmg_pkg::X_W-1:0];
            r_s1_e   <= e;
            r_s1_c2  <= r_s0_c2;
            r_l24    <= l_full[35:6];
            r_l_c2   <= lg_c2;
            r_t      <= t_prod[60:30];
            r_t_c2   <= r_l_c2;
            r_a_r    <= sq_r[bmg_pkg::SQRT_STEPS][bmg_pkg::R_W-1:0];
            r_a_th   <= th_prod[60:30];
            r_a_quad <= turn[31:30];
            r_x_r    <= r_a_r;
            r_x_th   <= r_a_th;
            r_x_x2   <= x2_prod[61:30];
            r_x_quad <= r_a_quad;
            r_q_r    <= tr_p[bmg_pkg::TRIG_STEPS][TPW-1:2];
            r_q_cneg <= cv[bmg_pkg::SUM_W-1];
            r_q_sneg <= sv[bmg_pkg::SUM_W-1];
            r_q_cmag <= c_abs[bmg_pkg::MAG_W-1:0];
            r_q_smag <= s_abs[bmg_pkg::MAG_W-1:0];
            r_p_c    <= bmg_pkg::PROD_W'(r_q_r) * bmg_pkg::PROD_W'(r_q_cmag);
            r_p_s    <= bmg_pkg::PROD_W'(r_q_r) * bmg_pkg::PROD_W'(r_q_smag);
            r_p_cneg <= r_q_cneg;
            r_p_sneg <= r_q_sneg;
        end
    end

    // log2 chain
    assign lg_v[0] = r_s1_vld;
    assign lg_x[0] = r_s1_x;
    assign lg_f[0] = '0;
    assign lg_p[0] = {r_s1_e, r_s1_c2};

    for (genvar k = 0; k < bmg_pkg::LOG_STEPS; k++) begin : g_log
        bmg_log_cell #(
            .PW (LPW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (lg_v[k]),
            .i_x     (lg_x[k]),
            .i_frac  (lg_f[k]),
            .i_pass  (lg_p[k]),
            .o_vld   (lg_v[k+1]),
            .o_x     (lg_x[k+1]),
            .o_frac  (lg_f[k+1]),
            .o_pass  (lg_p[k+1])
        );
    end

    // square root chain, one root bit per cell
    assign sq_v[0] = r_t_vld;
    assign sq_x[0] = {r_t, 24'd0};
    assign sq_r[0] = '0;
    assign sq_p[0] = r_t_c2;

    for (genvar k = 0; k < bmg_pkg::SQRT_STEPS; k++) begin : g_sqrt
        bmg_sqrt_cell #(
            .BITPOS (bmg_pkg::V_W - 1 - 2 * k),
            .PW     (UB)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (sq_v[k]),
            .i_v     (sq_x[k]),
            .i_res   (sq_r[k]),
            .i_pass  (sq_p[k]),
            .o_vld   (sq_v[k+1]),
            .o_v     (sq_x[k+1]),
            .o_res   (sq_r[k+1]),
            .o_pass  (sq_p[k+1])
        );
    end

    // Taylor chain: sine and cosine in step, sine stops one term early
    assign tr_v[0]  = r_x_vld;
    assign tr_x2[0] = r_x_x2;
    assign tr_st[0] = bmg_pkg::TERM_W'(r_x_th);
    assign tr_ct[0] = bmg_pkg::TERM_W'(1) << 30;
    assign tr_ss[0] = $signed(bmg_pkg::SUM_W'(r_x_th));
    assign tr_cs[0] = $signed(bmg_pkg::SUM_W'(1) << 30);
    assign tr_p[0]  = {r_x_r, r_x_quad};

    for (genvar k = 0; k < bmg_pkg::TRIG_STEPS; k++) begin : g_trig
        bmg_trig_cell #(
            .N      (k + 1),
            .SIN_ON (k < bmg_pkg::SIN_STEPS),
            .PW     (TPW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_vld    (tr_v[k]),
            .i_x2     (tr_x2[k]),
            .i_s_term (tr_st[k]),
            .i_c_term (tr_ct[k]),
            .i_s_sum  (tr_ss[k]),
            .i_c_sum  (tr_cs[k]),
            .i_pass   (tr_p[k]),
            .o_vld    (tr_v[k+1]),
            .o_x2     (tr_x2[k+1]),
            .o_s_term (tr_st[k+1]),
            .o_c_term (tr_ct[k+1]),
            .o_s_sum  (tr_ss[k+1]),
            .o_c_sum  (tr_cs[k+1]),
            .o_pass   (tr_p[k+1])
        );
    end

    // fold the quadrant back in
    always_comb begin
        s_fin = tr_ss[bmg_pkg::TRIG_STEPS];
        c_fin = tr_cs[bmg_pkg::TRIG_STEPS];
        case (bmg_pkg::t_quad'(tr_p[bmg_pkg::TRIG_STEPS][1:0]))
            bmg_pkg::QUAD_I: begin
                cv = c_fin;
                sv = s_fin;
            end
            bmg_pkg::QUAD_II: begin
                cv = -s_fin;
                sv = c_fin;
            end
            bmg_pkg::QUAD_III: begin
                cv = -c_fin;
                sv = -s_fin;
            end
            default: begin
                cv = s_fin;
                sv = -c_fin;
            end
        endcase
        c_abs = cv[bmg_pkg::SUM_W-1] ? -cv : cv;
        s_abs = sv[bmg_pkg::SUM_W-1] ? -sv : sv;
    end

    always_comb begin
        pair.cos_smp = f_scale(r_p_c, r_p_cneg);
        pair.sin_smp = f_scale(r_p_s, r_p_sneg);
    end

    assign last_vld = r_p_vld;

    bmg_out_buf u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (en && last_vld),
        .i_pair   (pair),
        .o_full   (full),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tlast  (o_m_axis_tlast)
    );

endmodule
`default_nettype wire

[rtl/core/bmg_log_cell.sv]
// One squaring step of the log2 chain: yields one fraction bit per cell.
`default_nettype none
module bmg_log_cell #(
    parameter int PW = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_vld,
    input  wire logic [bmg_pkg::X_W-1:0]       i_x,
    input  wire logic [bmg_pkg::FRAC_W-1:0]    i_frac,
    input  wire logic [PW-1:0]                 i_pass,
    output logic                               o_vld,
    output logic [bmg_pkg::X_W-1:0]            o_x,
    output logic [bmg_pkg::FRAC_W-1:0]         o_frac,
    output logic [PW-1:0]                      o_pass
);

    logic [2*bmg_pkg::X_W-1:0] sq;
    logic [31:0]               y;
    logic [bmg_pkg::X_W-1:0]   n_x;
    logic [bmg_pkg::FRAC_W-1:0] n_frac;
    logic                      r_vld;
    logic [bmg_pkg::X_W-1:0]   r_x;
    logic [bmg_pkg::FRAC_W-1:0] r_frac;
    logic [PW-1:0]             r_pass;

    always_comb begin
        sq     = (2*bmg_pkg::X_W)'(i_x) * (2*bmg_pkg::X_W)'(i_x);
        y      = sq[61:30];
        // square reached [2,4): fraction bit is one, halve back into [1,2)
        n_x    = y[31] ? y[31:1] : y[30:0];
        n_frac = {i_frac[bmg_pkg::FRAC_W-2:0], y[31]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_frac <= n_frac;
            r_pass <= i_pass;
        end
    end

    assign o_vld  = r_vld;
    assign o_x    = r_x;
    assign o_frac = r_frac;
    assign o_pass = r_pass;

endmodule
`default_nettype wire

[rtl/core/bmg_sqrt_cell.sv]
// One restoring step of the integer square root: settles one root bit.
`default_nettype none
module bmg_sqrt_cell #(
    parameter int BITPOS = 54,
    parameter int PW     = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_vld,
    input  wire logic [bmg_pkg::V_W-1:0]   i_v,
    input  wire logic [bmg_pkg::V_W-1:0]   i_res,
    input  wire logic [PW-1:0]             i_pass,
    output logic                           o_vld,
    output logic [bmg_pkg::V_W-1:0]        o_v,
    output logic [bmg_pkg::V_W-1:0]        o_res,
    output logic [PW-1:0]                  o_pass
);

    localparam logic [bmg_pkg::V_W-1:0] BIT = bmg_pkg::V_W'(1) << BITPOS;

    logic [bmg_pkg::V_W:0]   trial;
    logic [bmg_pkg::V_W-1:0] n_v;
    logic [bmg_pkg::V_W-1:0] n_res;
    logic                    r_vld;
    logic [bmg_pkg::V_W-1:0] r_v;
    logic [bmg_pkg::V_W-1:0] r_res;
    logic [PW-1:0]           r_pass;

    always_comb begin
        trial = {1'b0, i_res} + {1'b0, BIT};
        if ({1'b0, i_v} >= trial) begin
            n_v   = i_v - trial[bmg_pkg::V_W-1:0];
            n_res = (i_res >> 1) + BIT;
        end else begin
            n_v   = i_v;
            n_res = i_res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v    <= n_v;
            r_res  <= n_res;
            r_pass <= i_pass;
        end
    end

    assign o_vld  = r_vld;
    assign o_v    = r_v;
    assign o_res  = r_res;
    assign o_pass = r_pass;

endmodule
`default_nettype wire

[rtl/core/bmg_trig_cell.sv]
// One Taylor step for sine and cosine side by side: multiply by x^2, then
// divide by a constant via a reciprocal multiply; sine holds if SIN_ON is 0.
`default_nettype none
module bmg_trig_cell #(
    parameter int N      = 1,
    parameter bit SIN_ON = 1'b1,
    parameter int PW     = 30
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire logic                              i_vld,
    input  wire logic [bmg_pkg::X2_W-1:0]          i_x2,
    input  wire logic [bmg_pkg::TERM_W-1:0]        i_s_term,
    input  wire logic [bmg_pkg::TERM_W-1:0]        i_c_term,
    input  wire logic signed [bmg_pkg::SUM_W-1:0]  i_s_sum,
    input  wire logic signed [bmg_pkg::SUM_W-1:0]  i_c_sum,
    input  wire logic [PW-1:0]                     i_pass,
    output logic                                   o_vld,
    output logic [bmg_pkg::X2_W-1:0]               o_x2,
    output logic [bmg_pkg::TERM_W-1:0]             o_s_term,
    output logic [bmg_pkg::TERM_W-1:0]             o_c_term,
    output logic signed [bmg_pkg::SUM_W-1:0]       o_s_sum,
    output logic signed [bmg_pkg::SUM_W-1:0]       o_c_sum,
    output logic [PW-1:0]                          o_pass
);

    localparam int          S_DIV = 2 * N * (2 * N + 1);
    localparam int          C_DIV = (2 * N - 1) * (2 * N);
    localparam int          S_K   = 32 + $clog2(S_DIV);
    localparam int          C_K   = 32 + $clog2(C_DIV);
    localparam logic [63:0] S_MUL = ((64'd1 << S_K) + 64'(S_DIV) - 64'd1) / 64'(S_DIV);
    localparam logic [63:0] C_MUL = ((64'd1 << C_K) + 64'(C_DIV) - 64'd1) / 64'(C_DIV);
    localparam bit          SUB   = ((N % 2) == 1);

    localparam int TW = bmg_pkg::TERM_W;

    logic [2*TW-1:0] s_sq, c_sq;
    logic [64:0]     s_prod, c_prod;
    logic [TW-1:0]   s_q, c_q;
    logic signed [bmg_pkg::SUM_W-1:0] n_s_sum, n_c_sum;

    // stage A: term * x^2
    logic                              r_a_vld;
    logic [TW-1:0]                     r_a_s, r_a_c;
    logic [bmg_pkg::X2_W-1:0]          r_a_x2;
    logic signed [bmg_pkg::SUM_W-1:0]  r_a_s_sum, r_a_c_sum;
    logic [TW-1:0]                     r_a_s_keep;
    logic [PW-1:0]                     r_a_pass;
    // stage B: divided term and running sums
    logic                              r_vld;
    logic [TW-1:0]                     r_s_term, r_c_term;
    logic [bmg_pkg::X2_W-1:0]          r_x2;
    logic signed [bmg_pkg::SUM_W-1:0]  r_s_sum, r_c_sum;
    logic [PW-1:0]                     r_pass;

    always_comb begin
        s_sq = (2*TW)'(i_s_term) * (2*TW)'(i_x2);
        c_sq = (2*TW)'(i_c_term) * (2*TW)'(i_x2);
    end

    always_comb begin
        s_prod = {33'd0, r_a_s} * {32'd0, S_MUL[32:0]};
        c_prod = {33'd0, r_a_c} * {32'd0, C_MUL[32:0]};
        s_q    = TW'(s_prod >> S_K);
        c_q    = TW'(c_prod >> C_K);
        if (SUB) begin
            n_s_sum = r_a_s_sum - $signed({3'd0, s_q});
            n_c_sum = r_a_c_sum - $signed({3'd0, c_q});
        end else begin
            n_s_sum = r_a_s_sum + $signed({3'd0, s_q});
            n_c_sum = r_a_c_sum + $signed({3'd0, c_q});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_vld   <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_vld   <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_s      <= s_sq[61:30];
            r_a_c      <= c_sq[61:30];
            r_a_x2     <= i_x2;
            r_a_s_sum  <= i_s_sum;
            r_a_c_sum  <= i_c_sum;
            r_a_s_keep <= i_s_term;
            r_a_pass   <= i_pass;

            r_x2     <= r_a_x2;
            r_c_term <= c_q;
            r_c_sum  <= n_c_sum;
            r_pass   <= r_a_pass;
            if (SIN_ON) begin
                r_s_term <= s_q;
                r_s_sum  <= n_s_sum;
            end else begin
                r_s_term <= r_a_s_keep;
                r_s_sum  <= r_a_s_sum;
            end
        end
    end

    assign o_vld    = r_vld;
    assign o_x2     = r_x2;
    assign o_s_term = r_s_term;
    assign o_c_term = r_c_term;
    assign o_s_sum  = r_s_sum;
    assign o_c_sum  = r_c_sum;
    assign o_pass   = r_pass;

endmodule
`default_nettype wire

[rtl/core/bmg_out_buf.sv]
// Output stage: one pending pair plus the output word, cosine then sine.
`default_nettype none
module bmg_out_buf (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_load,
    input  wire bmg_pkg::t_pair                i_pair,
    output logic                               o_full,
    output logic                               o_tvalid,
    input  wire logic                          i_tready,
    output logic [bmg_pkg::SAMPLE_W-1:0]       o_tdata,
    output logic                               o_tlast
);

    logic                          r_pend_vld;
    bmg_pkg::t_pair                r_pend;
    logic                          r_out_vld;
    logic                          r_out_last;
    logic [bmg_pkg::SAMPLE_W-1:0]  r_out_data;
    logic [bmg_pkg::SAMPLE_W-1:0]  r_cur_sin;

    logic out_free;
    logic send_sin;
    logic move;

    always_comb begin
        out_free = !r_out_vld || i_tready;
        send_sin = out_free && r_out_vld && !r_out_last;
        move     = out_free && !send_sin && r_pend_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_out_last <= 1'b0;
        end else begin
            if (i_load) begin
                r_pend_vld <= 1'b1;
            end else if (move) begin
                r_pend_vld <= 1'b0;
            end
            if (send_sin) begin
                r_out_vld  <= 1'b1;
                r_out_last <= 1'b1;
            end else if (move) begin
                r_out_vld  <= 1'b1;
                r_out_last <= 1'b0;
            end else if (out_free) begin
                r_out_vld  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pend <= i_pair;
        end
        if (send_sin) begin
            r_out_data <= r_cur_sin;
        end else if (move) begin
            r_out_data <= r_pend.cos_smp;
            r_cur_sin  <= r_pend.sin_smp;
        end
    end

    assign o_full   = r_pend_vld;
    assign o_tvalid = r_out_vld;
    assign o_tdata  = r_out_data;
    assign o_tlast  = r_out_last;

endmodule
`default_nettype wire

[tb/sv/box_muller_gaussian_pair_tb.sv]
// Self-checking testbench for the Box-Muller Gaussian pair generator.
`default_nettype none
module box_muller_gaussian_pair_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int UBITS     = 16;
    localparam int FBITS     = 12;
    localparam int WDOG_MAX  = 20000;
    localparam int LATENCY   = 90;
    localparam int N_RANDOM  = 600;

    typedef struct packed {
        logic [15:0] smp;
        logic        lst;
    } t_sample;

    // fixed-point Box-Muller predictor
    function automatic logic [63:0] log2_q30(logic [63:0] m);
        logic [63:0] x;
        logic [63:0] frac;
        int e;
        frac = 0;
        e = 0;
        while (e < 63 && (m >> (e + 1)) != 0) e++;
        x = (e <= 30) ? (m << (30 - e)) : (m >> (e - 30));
        for (int i = 0; i < 30; i++) begin
            x = (x * x) >> 30;
            frac = frac << 1;
            if (x >= (64'd2 << 30)) begin
                frac = frac | 1;
                x = x >> 1;
            end
        end
        return (64'(e) << 30) + frac;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] scale_sample(logic [63:0] r, logic signed [63:0] trig);
        logic [63:0] mag;
        logic [63:0] p;
        logic        neg;
        neg = trig < 0;
        mag = neg ? -trig : trig;
        p = (r * mag + (64'd1 << (54 - FBITS - 1))) >> (54 - FBITS);
        if (neg) return (p > 32768) ? 16'h8000 : 16'(-p);
        return (p > 32767) ? 16'h7fff : p[15:0];
    endfunction

    function automatic void gaussian_pair(input logic [15:0] c1, input logic [15:0] c2,
                                          output logic [15:0] cs, output logic [15:0] sn);
        logic [63:0] lg, l24, t, r, p, f, th, x2, term;
        logic signed [63:0] s, c, cv, sv;
        logic [1:0] quad;
        lg  = log2_q30(64'(c1) + 1);
        l24 = ((64'(UBITS) << 30) - lg) >> 6;
        t   = (l24 * 64'd1488522236) >> 30;
        r   = int_sqrt(t << 24);
        p   = (64'(c2) << (32 - UBITS)) & 64'hffff_ffff;
        quad = p[31:30];
        f   = p & ((64'd1 << 30) - 1);
        th  = (f * 64'd1686629713) >> 30;
        x2  = (th * th) >> 30;
        term = th;
        s = th;
        for (int n = 1; n <= 7; n++) begin
            term = ((term * x2) >> 30) / (2 * n * (2 * n + 1));
            s = (n & 1) ? s - term : s + term;
        end
        term = 64'd1 << 30;
        c = term;
        for (int n = 1; n <= 8; n++) begin
            term = ((term * x2) >> 30) / ((2 * n - 1) * (2 * n));
            c = (n & 1) ? c - term : c + term;
        end
        case (bmg_pkg::t_quad'(quad))
            bmg_pkg::QUAD_I:   begin cv = c;  sv = s;  end
            bmg_pkg::QUAD_II:  begin cv = -s; sv = c;  end
            bmg_pkg::QUAD_III: begin cv = -c; sv = -s; end
            default:           begin cv = s;  sv = -c; end
        endcase
        cs = scale_sample(r, cv);
        sn = scale_sample(r, sv);
    endfunction

    class sample_board;
        t_sample pending[$];
        int      n_fail;

        function void note_pair(logic [31:0] w);
            logic [15:0] cs, sn;
            gaussian_pair(w[15:0], w[31:16], cs, sn);
            pending.push_back('{smp: cs, lst: 1'b0});
            pending.push_back('{smp: sn, lst: 1'b1});
        endfunction

        function void check_sample(logic [15:0] smp, logic lst);
            t_sample want;
            if (pending.size() == 0) begin
                $error("unexpected word: sample %0d last %0b", $signed(smp), lst);
                n_fail++;
                return;
            end
            want = pending.pop_front();
            if (smp !== want.smp) begin
                $error("sample: expected %0d, got %0d", $signed(want.smp), $signed(smp));
                n_fail++;
            end
            if (lst !== want.lst) begin
                $error("last: expected %0b, got %0b", want.lst, lst);
                n_fail++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata;   // [15:0] uniform_radius, [31:16] uniform_angle
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [15:0] o_m_axis_tdata;   // [15:0] sample
    logic        o_m_axis_tlast;

    box_muller_gaussian_pair dut (.*);

    sample_board board = new();
    int send_idle_pct;
    int recv_stall_pct;
    int wdog;

    always begin
        i_clk = 1'b0; #2;
        i_clk = 1'b1; #2;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            board.check_sample(o_m_axis_tdata, o_m_axis_tlast);
    end

    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            wdog = 0;
        else if (++wdog >= WDOG_MAX) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // called at a falling edge; valid stays high into the next word when no idle is drawn
    task automatic send_pair(logic [15:0] radius, logic [15:0] angle);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {angle, radius};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        board.note_pair({angle, radius});
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic random_pairs(int n);
        logic [15:0] r;
        for (int k = 0; k < n; k++) begin
            // bias some words to the radius extremes
            case ($urandom_range(7))
                0:       r = 16'($urandom_range(15));
                1:       r = 16'hffff - 16'($urandom_range(15));
                default: r = 16'($urandom);
            endcase
            send_pair(r, 16'($urandom));
        end
    endtask

    initial begin
        wdog = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b1;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // radius extremes against each quadrant boundary and mid-quadrant angles
        send_pair(16'h0000, 16'h0000);
        send_pair(16'h0000, 16'h4000);
        send_pair(16'h0000, 16'h8000);
        send_pair(16'h0000, 16'hc000);
        send_pair(16'h0000, 16'h2000);
        send_pair(16'h0000, 16'ha000);
        send_pair(16'hffff, 16'h1234);
        send_pair(16'hffff, 16'hffff);
        send_pair(16'h0001, 16'hffff);
        send_pair(16'h0001, 16'h6000);
        send_pair(16'h8000, 16'h0001);
        send_pair(16'h7fff, 16'he000);
        send_pair(16'hfffe, 16'h3fff);
        send_pair(16'h5555, 16'haaaa);
        send_pair(16'haaaa, 16'h5555);
        send_pair(16'h0100, 16'h7fff);
        drain();

        random_pairs(150);
        send_idle_pct = 63;
        random_pairs(150);
        drain();
        send_idle_pct  = 0;
        recv_stall_pct = 63;
        random_pairs(150);
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        random_pairs(150);

        drain();
        recv_stall_pct = 0;
        repeat (LATENCY) @(posedge i_clk);
        if (board.n_fail == 0 && board.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire

[box_muller_gaussian_pair.f]
rtl/core/bmg_pkg.sv
rtl/core/bmg_log_cell.sv
rtl/core/bmg_sqrt_cell.sv
rtl/core/bmg_trig_cell.sv
rtl/core/bmg_out_buf.sv
rtl/core/box_muller_gaussian_pair.sv
tb/sv/box_muller_gaussian_pair_tb.sv
